@@ rtl/swm_pkg.sv @@
// Shared types and constants of the sliding window median cost block.
package swm_pkg;

  localparam int COST_W = 42;
  localparam int CFG_W  = 11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_SUM
  } state_e;

  typedef struct packed {
    logic upd;
    logic restart;
    logic evict;
    logic clear;
  } cell_ctl_t;

endpackage

@@ rtl/swm_if.sv @@
// Handshake channel interfaces: sample input, cost output, window length write.
interface swm_smp_if #(
  parameter int SAMPLE_BITS = 32
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   restart;

  modport source (output valid, sample, restart, input ready);
  modport sink (input valid, sample, restart, output ready);
endinterface

interface swm_res_if import swm_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [COST_W-1:0] cost;

  modport source (output valid, cost, input ready);
  modport sink (input valid, cost, output ready);
endinterface

interface swm_cfg_if import swm_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] window_len;

  modport source (output valid, window_len, input ready);
  modport sink (input valid, window_len, output ready);
endinterface

@@ rtl/swm_ram.sv @@
// Generic simple dual-port RAM with registered read.
module swm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/swm_cell.sv @@
// One cell of the sorted chain: holds one window sample, shifts on evict and insert.
module swm_cell import swm_pkg::*; #(
  parameter int SAMPLE_BITS = 32,
  parameter bit IS_HEAD     = 1'b0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cell_ctl_t              ctl_i,
  input  logic [SAMPLE_BITS-1:0] smp_i,
  input  logic [SAMPLE_BITS-1:0] ev_i,
  input  logic [SAMPLE_BITS-1:0] lft_r_i,
  input  logic                   lft_rvld_i,
  input  logic                   lft_ins_i,
  input  logic [SAMPLE_BITS-1:0] rgt_val_i,
  input  logic                   rgt_vld_i,
  output logic [SAMPLE_BITS-1:0] val_o,
  output logic                   vld_o,
  output logic [SAMPLE_BITS-1:0] r_o,
  output logic                   rvld_o,
  output logic                   ins_o
);

  logic [SAMPLE_BITS-1:0] val_q, val_d;
  logic                   vld_q, vld_d;
  logic                   rm;
  logic [SAMPLE_BITS-1:0] r_val;
  logic                   r_vld;
  logic                   ins;

  always_comb begin
    rm    = ctl_i.evict && vld_q && (val_q >= ev_i);
    r_val = rm ? rgt_val_i : val_q;
    r_vld = rm ? rgt_vld_i : vld_q;
    ins   = !r_vld || (r_val > smp_i);
    if (ctl_i.restart) begin
      val_d = smp_i;
      vld_d = IS_HEAD;
    end else if (lft_ins_i) begin
      val_d = lft_r_i;
      vld_d = lft_rvld_i;
    end else if (ins) begin
      val_d = smp_i;
      vld_d = 1'b1;
    end else begin
      val_d = r_val;
      vld_d = r_vld;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.clear) begin
      vld_q <= 1'b0;
    end else if (ctl_i.upd) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.upd) begin
      val_q <= val_d;
    end
  end

  assign val_o  = val_q;
  assign vld_o  = vld_q;
  assign r_o    = r_val;
  assign rvld_o = r_vld;
  assign ins_o  = ins;

endmodule

@@ rtl/sliding_window_median_cost.sv @@
// Top level: sliding window median absolute deviation sum over a sorted cell chain.
//
//   channel  dir  beat fields           accepted when
//   smp_i    in   sample, restart       smp_i.valid && smp_i.ready
//   res_o    out  cost                  res_o.valid && res_o.ready
//   cfg_i    in   window_len            cfg_i.valid && cfg_i.ready
//
// Each item passes through ST_UPD, which shifts the sorted chain (evict and insert at once),
// and then ST_SUM, which updates the lower-half and total sums and forms the cost.
// The next sample is taken in ST_SUM, while the sums of the last one are still being formed.
// ST_SUM holds while its result finds the output register still full.
// Reset clears cell valid bits directly: no clearing pass; a window_len write empties the window.
module sliding_window_median_cost import swm_pkg::*; #(
  parameter int WINDOW_MAX  = 1024,
  parameter int SAMPLE_BITS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  swm_smp_if.sink  smp_i,
  swm_res_if.source res_o,
  swm_cfg_if.sink  cfg_i
);

  localparam int LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  state_e state_q, state_d;
  cell_ctl_t ctl;

  logic [LEN_W-1:0]       len_q, len_d;
  logic [LEN_W-1:0]       hb_q, hb_d;
  logic [IDX_W-1:0]       hm1_q, hm1_d;
  logic                   odd_q;
  logic [LEN_W-1:0]       fill_q, fill_d;
  logic [IDX_W-1:0]       pos_q, pos_d;
  logic [IDX_W-1:0]       waddr;
  logic [LEN_W-1:0]       pos_inc;
  logic [COST_W-1:0]      lo_q, tot_q;
  logic [SAMPLE_BITS-1:0] s_q;
  logic                   restart_q;
  logic [SAMPLE_BITS-1:0] ev_q;
  logic                   evict_q;
  logic                   prod_q;
  logic [SAMPLE_BITS-1:0] ohm1_q, oh_q;
  logic                   ohm1v_q, ohv_q;
  logic                   res_valid_q;
  logic [COST_W-1:0]      cost_q;

  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic                   evict;
  logic                   in_acc, cfg_acc, sum_go;
  logic [31:0]            cfg_len32;

  logic [SAMPLE_BITS-1:0] cell_val  [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]  cell_vld;
  logic [SAMPLE_BITS-1:0] cell_r    [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]  cell_rvld;
  logic [WINDOW_MAX-1:0]  cell_ins;

  logic [SAMPLE_BITS-1:0] bv_hm1, bv_h;
  logic                   bvv_hm1, bvv_h;

  logic [COST_W-1:0] s42, v42, oh42, rv42, lo_b, tot_b, lo1, lo2, tot2, m42, cost_d;
  logic              a_lt, b_lt;
  logic [SAMPLE_BITS-1:0] r_v;
  logic              r_vld;

  assign in_acc  = smp_i.valid && smp_i.ready;
  assign cfg_acc = cfg_i.valid && cfg_i.ready;
  assign sum_go  = (state_q == ST_SUM) && (!prod_q || !res_valid_q || res_o.ready);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_UPD;
      end
      ST_UPD: begin
        state_d = ST_SUM;
      end
      ST_SUM: begin
        if (sum_go) state_d = in_acc ? ST_UPD : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs of the controller
  always_comb begin
    smp_i.ready = 1'b0;
    cfg_i.ready = 1'b0;
    ctl         = '0;
    case (state_q)
      ST_IDLE: begin
        smp_i.ready = 1'b1;
        cfg_i.ready = 1'b1;
        ctl.clear   = cfg_i.valid;
      end
      ST_UPD: begin
        ctl.upd     = 1'b1;
        ctl.restart = restart_q;
        ctl.evict   = evict;
      end
      ST_SUM: begin
        smp_i.ready = sum_go;
      end
      default: begin
        smp_i.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // window length: saturate to the chain depth, treat zero as one
  always_comb begin
    cfg_len32 = 32'(cfg_i.window_len);
    if (cfg_len32 == 32'd0) begin
      len_d = LEN_W'(1);
    end else if (cfg_len32 > 32'(WINDOW_MAX)) begin
      len_d = LEN_W'(WINDOW_MAX);
    end else begin
      len_d = LEN_W'(cfg_len32);
    end
    hb_d  = LEN_W'(((LEN_W + 1)'(len_d) + (LEN_W + 1)'(1)) >> 1);
    hm1_d = IDX_W'(hb_d - LEN_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_W'(1);
      hb_q  <= LEN_W'(1);
      hm1_q <= '0;
      odd_q <= 1'b1;
    end else if (cfg_acc) begin
      len_q <= len_d;
      hb_q  <= hb_d;
      hm1_q <= hm1_d;
      odd_q <= len_d[0];
    end
  end

  // arrival ring
  always_comb begin
    evict   = !restart_q && (fill_q == len_q);
    waddr   = restart_q ? '0 : pos_q;
    pos_inc = LEN_W'(waddr) + LEN_W'(1);
    pos_d   = (pos_inc >= len_q) ? '0 : IDX_W'(pos_inc);
    if (restart_q) begin
      fill_d = LEN_W'(1);
    end else if (evict) begin
      fill_d = fill_q;
    end else begin
      fill_d = fill_q + LEN_W'(1);
    end
  end

  swm_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ctl.upd),
    .waddr_i (waddr),
    .wdata_i (s_q),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata)
  );

  // sorted chain
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic [SAMPLE_BITS-1:0] lft_r, rgt_val;
    logic                   lft_rvld, lft_ins, rgt_vld;

    if (i == 0) begin : g_head
      assign lft_r    = '0;
      assign lft_rvld = 1'b0;
      assign lft_ins  = 1'b0;
    end else begin : g_body
      assign lft_r    = cell_r[i-1];
      assign lft_rvld = cell_rvld[i-1];
      assign lft_ins  = cell_ins[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_tail
      assign rgt_val = '0;
      assign rgt_vld = 1'b0;
    end else begin : g_inner
      assign rgt_val = cell_val[i+1];
      assign rgt_vld = cell_vld[i+1];
    end

    swm_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .IS_HEAD     (i == 0)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .smp_i      (s_q),
      .ev_i       (ram_rdata),
      .lft_r_i    (lft_r),
      .lft_rvld_i (lft_rvld),
      .lft_ins_i  (lft_ins),
      .rgt_val_i  (rgt_val),
      .rgt_vld_i  (rgt_vld),
      .val_o      (cell_val[i]),
      .vld_o      (cell_vld[i]),
      .r_o        (cell_r[i]),
      .rvld_o     (cell_rvld[i]),
      .ins_o      (cell_ins[i])
    );
  end

  // pick the cells at the median boundary
  always_comb begin
    bv_hm1  = '0;
    bv_h    = '0;
    bvv_hm1 = 1'b0;
    bvv_h   = 1'b0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      bv_hm1  = bv_hm1 | (cell_val[i] & {SAMPLE_BITS{IDX_W'(i) == hm1_q}});
      bvv_hm1 = bvv_hm1 | (cell_vld[i] && (IDX_W'(i) == hm1_q));
      bv_h    = bv_h | (cell_val[i] & {SAMPLE_BITS{LEN_W'(i) == hb_q}});
      bvv_h   = bvv_h | (cell_vld[i] && (LEN_W'(i) == hb_q));
    end
  end

  // sums and cost
  always_comb begin
    s42   = COST_W'(s_q);
    v42   = COST_W'(ev_q);
    oh42  = ohv_q ? COST_W'(oh_q) : '0;
    lo_b  = restart_q ? '0 : lo_q;
    tot_b = restart_q ? '0 : tot_q;
    a_lt  = evict_q && (ev_q <= ohm1_q);
    lo1   = a_lt ? (lo_b - v42 + oh42) : lo_b;
    r_v   = a_lt ? oh_q : ohm1_q;
    r_vld = a_lt ? ohv_q : ohm1v_q;
    rv42  = r_vld ? COST_W'(r_v) : '0;
    b_lt  = !r_vld || (s_q < r_v);
    lo2   = b_lt ? (lo1 + s42 - rv42) : lo1;
    tot2  = tot_b - (evict_q ? v42 : '0) + s42;
    m42   = odd_q ? COST_W'(bv_hm1) : '0;
    cost_d = tot2 - {lo2[COST_W-2:0], 1'b0} + m42;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      pos_q   <= '0;
      lo_q    <= '0;
      tot_q   <= '0;
      prod_q  <= 1'b0;
      evict_q <= 1'b0;
    end else if (cfg_acc) begin
      fill_q <= '0;
      pos_q  <= '0;
      lo_q   <= '0;
      tot_q  <= '0;
    end else if (state_q == ST_UPD) begin
      fill_q  <= fill_d;
      pos_q   <= pos_d;
      prod_q  <= (fill_d == len_q);
      evict_q <= evict;
    end else if (sum_go) begin
      lo_q  <= lo2;
      tot_q <= tot2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s_q       <= smp_i.sample;
      restart_q <= smp_i.restart;
    end
    if (state_q == ST_UPD) begin
      ev_q    <= ram_rdata;
      ohm1_q  <= bv_hm1;
      ohm1v_q <= bvv_hm1 && !restart_q;
      oh_q    <= bv_h;
      ohv_q   <= bvv_h && !restart_q;
    end
    if (sum_go && prod_q) begin
      cost_q <= cost_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (sum_go && prod_q) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  assign res_o.valid = res_valid_q;
  assign res_o.cost  = cost_q;

  a_fill_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= len_q)
    else $error("fill count above window length");

  a_pos_lt_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LEN_W'(pos_q) < len_q)
    else $error("ring position outside window");

  a_upd_then_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD |=> state_q == ST_SUM)
    else $error("chain update not followed by sum cycle");

  a_cells_match_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_UPD |-> LEN_W'($countones(cell_vld)) == fill_q)
    else $error("valid cells disagree with fill count");

  a_no_accept_in_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPD |-> !smp_i.ready && !cfg_i.ready)
    else $error("beat taken during chain update");

endmodule
